/* design/assert_macros.svh */
// Assertion helper macros used by the vpv_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check that a condition implies a consequence at the same edge.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Check that a condition implies a consequence at the next edge.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* design/vpv_pkg.sv */
// ----------------------------------------------------------------------------
// vpv_pkg: shared types and constants
// Payload structs, status codes and fixed point constants for the vertex unit.
// ----------------------------------------------------------------------------
`default_nettype none
package vpv_pkg;
    localparam int VW = 32;
    localparam int FB = 16;
    localparam int HW = 2 * VW + 4;
    localparam int NW = HW + FB;
    localparam int QD = 4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_WZERO = 2'd1;
    localparam logic [1:0] ST_SAT  = 2'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_PROJ = 1'b1;

    localparam logic [2:0] REG_LEFT = 3'd0;
    localparam logic [2:0] REG_TOP = 3'd1;
    localparam logic [2:0] REG_WIDTH = 3'd2;
    localparam logic [2:0] REG_HEIGHT = 3'd3;
    localparam logic [2:0] REG_NEAR = 3'd4;
    localparam logic [2:0] REG_FAR = 3'd5;

    localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam logic signed [VW-1:0] ONE_V = VW - 1 > FB ?
        VW'(64'sd1 <<< FB) : VMAX;

    typedef struct packed {
        logic             action;
        logic [3:0]       coeff_index;
        logic signed [VW-1:0] coeff_value;
        logic signed [VW-1:0] pos_x;
        logic signed [VW-1:0] pos_y;
        logic signed [VW-1:0] pos_z;
    } t_in;

    typedef struct packed {
        logic signed [VW-1:0] screen_x;
        logic signed [VW-1:0] screen_y;
        logic signed [VW-1:0] screen_depth;
        logic [1:0]           status;
    } t_out;

    typedef struct packed {
        logic signed [HW-1:0] hx;
        logic signed [HW-1:0] hy;
        logic signed [HW-1:0] hz;
        logic signed [HW-1:0] hw;
    } t_hom;

    // Saturate a wide signed value to VW bits.
    function automatic logic signed [VW-1:0] sat_v(input logic signed [NW+VW:0] a,
                                                  output logic f);
        f = 1'b0;
        if (a > (NW+VW+1)'(VMAX)) begin
            f = 1'b1;
            return VMAX;
        end
        if (a < (NW+VW+1)'(VMIN)) begin
            f = 1'b1;
            return VMIN;
        end
        return a[VW-1:0];
    endfunction
endpackage
`default_nettype wire

/* design/vpv_front.sv */
// ----------------------------------------------------------------------------
// vpv_front: matrix store and homogeneous transform
// Accept requests, update the matrix on loads, form H for projects.
// ----------------------------------------------------------------------------
`default_nettype none
module vpv_front import vpv_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    input  t_in  i_data,
    output logic o_take,
    input  wire  i_q_room,
    output logic o_valid,
    output t_hom o_hom
);
    logic signed [VW-1:0] r_m [16];
    logic signed [2*VW-1:0] r_p [16];
    logic r_v1;
    logic r_v2;
    t_hom r_hom;
    logic signed [VW-1:0] pv [4];

    assign o_take = i_q_room;
    assign pv[0] = i_data.pos_x;
    assign pv[1] = i_data.pos_y;
    assign pv[2] = i_data.pos_z;
    assign pv[3] = ONE_V;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 16; i++) begin
                r_m[i] <= (i % 5 == 0) ? ONE_V : '0;
            end
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid && o_take && i_data.action == ACT_PROJ;
            r_v2 <= r_v1;
            if (i_valid && o_take && i_data.action == ACT_LOAD) begin
                r_m[i_data.coeff_index] <= i_data.coeff_value;
            end
        end
    end

    // Stage one: sixteen products; the fourth row scales by one exactly.
    always_ff @(posedge i_clk) begin
        for (int r = 0; r < 4; r++) begin
            for (int c = 0; c < 4; c++) begin
                if (r == 3) begin
                    r_p[r*4+c] <= (2*VW)'(r_m[r*4+c]) <<< FB;
                end else begin
                    r_p[r*4+c] <= (2*VW)'(pv[r]) * (2*VW)'(r_m[r*4+c]);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hom.hx <= HW'(r_p[0]) + HW'(r_p[4]) + HW'(r_p[8]) + HW'(r_p[12]);
        r_hom.hy <= HW'(r_p[1]) + HW'(r_p[5]) + HW'(r_p[9]) + HW'(r_p[13]);
        r_hom.hz <= HW'(r_p[2]) + HW'(r_p[6]) + HW'(r_p[10]) + HW'(r_p[14]);
        r_hom.hw <= HW'(r_p[3]) + HW'(r_p[7]) + HW'(r_p[11]) + HW'(r_p[15]);
    end

    assign o_valid = r_v2;
    assign o_hom = r_hom;
endmodule
`default_nettype wire

/* design/vpv_queue.sv */
// ----------------------------------------------------------------------------
// vpv_queue: small FIFO between front and back
// Hold transformed vertices; report room with slack for the front pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module vpv_queue import vpv_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_push,
    input  t_hom i_data,
    output logic o_room,
    output logic o_valid,
    output t_hom o_data,
    input  wire  i_pop
);
    localparam int DEPTH = QD + 4;
    t_hom r_mem [DEPTH];
    logic [2:0] r_wp;
    logic [2:0] r_rp;
    logic [3:0] r_cnt;
    logic [3:0] n_cnt;

    assign o_valid = r_cnt != 4'd0;
    assign o_data = r_mem[r_rp];
    // Two items may already be in the front pipeline beyond the one taken now.
    assign o_room = r_cnt < 4'(DEPTH - 3);
    assign n_cnt = r_cnt + 4'(i_push) - 4'(i_pop && o_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 3'd1;
            if (i_pop && o_valid) r_rp <= r_rp + 3'd1;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_data;
    end
endmodule
`default_nettype wire

/* design/vpv_div.sv */
// ----------------------------------------------------------------------------
// vpv_div: pipelined rounding divider
// Compute H*S/W rounded to nearest, ties away from zero, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module vpv_div import vpv_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_en,
    input  wire signed [HW-1:0]  i_num,
    input  wire signed [HW-1:0]  i_den,
    output logic signed [NW+1:0] o_q
);
    localparam int ST = NW;
    logic [NW-1:0] r_n [ST+1];
    logic [HW-1:0] r_d [ST+1];
    logic [HW:0]   r_r [ST+1];
    logic [NW-1:0] r_q [ST+1];
    logic          r_s [ST+1];
    logic [NW:0]   rq;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0] <= NW'(i_num[HW-1] ? -i_num : i_num) << FB;
            r_d[0] <= i_den[HW-1] ? -i_den : i_den;
            r_s[0] <= i_num[HW-1] ^ i_den[HW-1];
            r_r[0] <= '0;
            r_q[0] <= '0;
            for (int k = 0; k < ST; k++) begin
                logic [HW+1:0] t;
                t = {r_r[k][HW:0], r_n[k][NW-1]};
                r_n[k+1] <= r_n[k] << 1;
                r_d[k+1] <= r_d[k];
                r_s[k+1] <= r_s[k];
                if (t >= (HW+2)'(r_d[k])) begin
                    r_r[k+1] <= (HW+1)'(t - (HW+2)'(r_d[k]));
                    r_q[k+1] <= {r_q[k][NW-2:0], 1'b1};
                end else begin
                    r_r[k+1] <= t[HW:0];
                    r_q[k+1] <= {r_q[k][NW-2:0], 1'b0};
                end
            end
        end
    end

    assign rq = (NW+1)'(r_q[ST]) +
        (NW+1)'({r_r[ST], 1'b0} >= (HW+2)'(r_d[ST]));
    assign o_q = r_s[ST] ? -(NW+2)'(rq) : (NW+2)'(rq);
endmodule
`default_nettype wire

/* design/vpv_back.sv */
// ----------------------------------------------------------------------------
// vpv_back: perspective divide and viewport map
// Divide by w, saturate, scale into viewport and depth range, register out.
// ----------------------------------------------------------------------------
`default_nettype none
module vpv_back import vpv_pkg::*; (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    input  t_hom          i_hom,
    output logic          o_pop,
    input  wire  [2:0]    i_cfg_idx,
    input  wire  [VW-1:0] i_cfg_data,
    input  wire           i_cfg_we,
    output logic          o_valid,
    output t_out          o_data,
    input  wire           i_stall
);
    localparam int LAT = NW + 3;
    logic signed [VW-1:0] r_left, r_top, r_wid, r_hgt, r_near, r_far;
    logic [LAT-1:0] r_vld;
    logic r_en;
    logic signed [NW+1:0] qx, qy, qz;
    logic [LAT-1:0] r_wz;
    logic signed [VW-1:0] r_nx, r_ny, r_nz;
    logic r_s1, r_wz1, r_v1;
    logic signed [2*VW+2:0] r_px, r_py, r_pz;
    logic r_s2, r_wz2, r_v2;
    logic r_ov;
    t_out r_out;
    logic fx, fy, fz, gx, gy, gz;
    logic signed [VW-1:0] nx, ny, nz, sx, sy, sz;
    logic signed [NW+VW:0] ex, ey, ez;

    // Whole pipe advances together; stall holds it when the output is full.
    assign r_en = !(r_ov && i_stall);
    assign o_pop = r_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0; r_top <= '0; r_wid <= '0; r_hgt <= '0;
            r_near <= '0; r_far <= ONE_V;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LEFT: r_left <= i_cfg_data;
                REG_TOP: r_top <= i_cfg_data;
                REG_WIDTH: r_wid <= i_cfg_data;
                REG_HEIGHT: r_hgt <= i_cfg_data;
                REG_NEAR: r_near <= i_cfg_data;
                REG_FAR: r_far <= i_cfg_data;
                default: ;
            endcase
        end
    end

    vpv_div u_dx (.i_clk, .i_en(r_en), .i_num(i_hom.hx), .i_den(i_hom.hw), .o_q(qx));
    vpv_div u_dy (.i_clk, .i_en(r_en), .i_num(i_hom.hy), .i_den(i_hom.hw), .o_q(qy));
    vpv_div u_dz (.i_clk, .i_en(r_en), .i_num(i_hom.hz), .i_den(i_hom.hw), .o_q(qz));

    always_comb begin
        nx = sat_v((NW+VW+1)'(qx), fx);
        ny = sat_v((NW+VW+1)'(qy), fy);
        nz = sat_v((NW+VW+1)'(qz), fz);
        ex = (NW+VW+1)'((r_px + (2*VW+3)'(64'sd1 <<< FB)) >>> (FB+1)) +
             (NW+VW+1)'(r_left);
        ey = (NW+VW+1)'((r_py + (2*VW+3)'(64'sd1 <<< FB)) >>> (FB+1)) +
             (NW+VW+1)'(r_top);
        ez = (NW+VW+1)'((r_pz + (2*VW+3)'(64'sd1 <<< (FB-1))) >>> FB) +
             (NW+VW+1)'(r_near);
        sx = sat_v(ex, gx);
        sy = sat_v(ey, gy);
        sz = sat_v(ez, gz);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_ov <= 1'b0;
        end else if (r_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
            r_v1 <= r_vld[NW];
            r_v2 <= r_v1;
            r_ov <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_en) begin
            r_wz <= {r_wz[LAT-2:0], i_hom.hw == '0};
            r_nx <= nx; r_ny <= ny; r_nz <= nz;
            r_s1 <= fx | fy | fz;
            r_wz1 <= r_wz[NW];
            r_px <= (2*VW+3)'((VW+2)'(ONE_V) + (VW+2)'(r_nx)) * (2*VW+3)'(r_wid);
            r_py <= (2*VW+3)'((VW+2)'(ONE_V) - (VW+2)'(r_ny)) * (2*VW+3)'(r_hgt);
            r_pz <= (2*VW+3)'(r_nz) * (2*VW+3)'((VW+1)'(r_far) - (VW+1)'(r_near));
            r_s2 <= r_s1;
            r_wz2 <= r_wz1;
            if (r_wz2) begin
                r_out <= '{screen_x: '0, screen_y: '0, screen_depth: '0, status: ST_WZERO};
            end else begin
                r_out <= '{screen_x: sx, screen_y: sy, screen_depth: sz,
                           status: (r_s2 | gx | gy | gz) ? ST_SAT : ST_OK};
            end
        end
    end

    assign o_valid = r_ov;
    assign o_data = r_out;
endmodule
`default_nettype wire

/* design/vertex_project_viewport_unit.sv */
// ----------------------------------------------------------------------------
// vertex_project_viewport_unit: vertex transform, divide and viewport map
// Throughput: one request per cycle while not stalled; set by the fully pipelined divider.
// Loads update the matrix and give no result.
// Reset: synchronous active low; matrix returns to identity, far to 1.0.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_project_viewport_unit import vpv_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_valid,
    input  t_in          i_data,
    output logic         o_stall,
    output logic         o_valid,
    output t_out         o_data,
    input  wire          i_stall,
    input  wire          i_cfg_valid,
    output logic         o_cfg_ready,
    input  wire  [2:0]   i_cfg_index,
    input  wire  [VW-1:0] i_cfg_data
);
    logic take, fv, qroom, qv, qpop, bvalid;
    t_hom fh, qh;

    // Front: hold input when queue cannot absorb in-flight work.
    vpv_front u_front (.i_clk, .i_rst_n, .i_valid, .i_data, .o_take(take),
                       .i_q_room(qroom), .o_valid(fv), .o_hom(fh));
    assign o_stall = !take;

    vpv_queue u_q (.i_clk, .i_rst_n, .i_push(fv), .i_data(fh), .o_room(qroom),
                   .o_valid(qv), .o_data(qh), .i_pop(qpop));

    // Back: advance only when the output register is free.
    vpv_back u_back (.i_clk, .i_rst_n, .i_valid(qv && qpop), .i_hom(qh), .o_pop(qpop),
                     .i_cfg_idx(i_cfg_index), .i_cfg_data(i_cfg_data),
                     .i_cfg_we(i_cfg_valid), .o_valid(bvalid), .o_data(o_data),
                     .i_stall);
    assign o_valid = bvalid;
    assign o_cfg_ready = 1'b1;
endmodule
`default_nettype wire

/* design/vpv_checker.sv */
// ----------------------------------------------------------------------------
// vpv_checker: port level checks
// Watch the vertex unit's ports for protocol and status consistency.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module vpv_checker import vpv_pkg::*; (
    input wire  i_clk,
    input wire  i_rst_n,
    input wire  o_valid,
    input wire  i_stall,
    input t_out o_data
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_data))
    `ASSERT_IMPL(a_stat, i_clk, i_rst_n, o_valid, o_data.status != 2'd3)
    `ASSERT_IMPL(a_wz, i_clk, i_rst_n, o_valid && o_data.status == ST_WZERO,
                 o_data.screen_x == '0 && o_data.screen_depth == '0)
endmodule
bind vertex_project_viewport_unit vpv_checker u_chk (.i_clk, .i_rst_n, .o_valid,
    .i_stall, .o_data);
`default_nettype wire
